// ===== rtl/xmd_pkg.sv =====
`default_nettype none

package xmd_pkg;

    localparam int ByteW   = 8;
    localparam int WordW   = 16;
    localparam int FormW   = 3;
    localparam int LenW    = 3;

    // Instruction form codes as reported in the result record.
    localparam logic [FormW-1:0] FORM_IMM_REG = 3'd0;
    localparam logic [FormW-1:0] FORM_RM_REG  = 3'd1;
    localparam logic [FormW-1:0] FORM_IMM_RM  = 3'd2;
    localparam logic [FormW-1:0] FORM_MEM_ACC = 3'd3;
    localparam logic [FormW-1:0] FORM_ACC_MEM = 3'd4;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_UNKNOWN = 1'b1;

    // Opcode match masks and patterns.
    localparam logic [ByteW-1:0] MASK_IMM_REG = 8'hf0;
    localparam logic [ByteW-1:0] PAT_IMM_REG  = 8'hb0;
    localparam logic [ByteW-1:0] MASK_RM_REG  = 8'hfc;
    localparam logic [ByteW-1:0] PAT_RM_REG   = 8'h88;
    localparam logic [ByteW-1:0] MASK_PAIR    = 8'hfe;
    localparam logic [ByteW-1:0] PAT_IMM_RM   = 8'hc6;
    localparam logic [ByteW-1:0] PAT_MEM_ACC  = 8'ha0;
    localparam logic [ByteW-1:0] PAT_ACC_MEM  = 8'ha2;

    localparam logic [1:0] MOD_MEM    = 2'd0;
    localparam logic [1:0] MOD_DISP8  = 2'd1;
    localparam logic [1:0] MOD_DISP16 = 2'd2;
    localparam logic [2:0] RM_DIRECT  = 3'd6;

    typedef struct packed {
        logic [FormW-1:0] form;
        logic             status;
        logic             word_flag;
        logic             direction_flag;
        logic [1:0]       mode;
        logic [2:0]       reg_field;
        logic [2:0]       rm_field;
        logic [WordW-1:0] displacement;
        logic [WordW-1:0] immediate;
        logic [LenW-1:0]  length;
        logic [WordW-1:0] start_offset;
    } t_result;

    function automatic logic op_known(input logic [ByteW-1:0] op);
        return ((op & MASK_IMM_REG) == PAT_IMM_REG) || ((op & MASK_RM_REG) == PAT_RM_REG)
            || ((op & MASK_PAIR) == PAT_IMM_RM) || ((op & MASK_PAIR) == PAT_MEM_ACC)
            || ((op & MASK_PAIR) == PAT_ACC_MEM);
    endfunction

    // Form of an opcode; an unknown opcode maps to immediate-to-register.
    function automatic logic [FormW-1:0] op_form(input logic [ByteW-1:0] op);
        logic [FormW-1:0] f;
        priority if ((op & MASK_IMM_REG) == PAT_IMM_REG) f = FORM_IMM_REG;
        else if ((op & MASK_RM_REG) == PAT_RM_REG)       f = FORM_RM_REG;
        else if ((op & MASK_PAIR) == PAT_IMM_RM)         f = FORM_IMM_RM;
        else if ((op & MASK_PAIR) == PAT_MEM_ACC)        f = FORM_MEM_ACC;
        else if ((op & MASK_PAIR) == PAT_ACC_MEM)        f = FORM_ACC_MEM;
        else                                             f = FORM_IMM_REG;
        return f;
    endfunction

    function automatic logic op_wide(input logic [ByteW-1:0] op);
        return (op_form(op) == FORM_IMM_REG) ? op[3] : op[0];
    endfunction

    // Number of displacement bytes that follow, from 0 to 2.
    function automatic logic [1:0] disp_bytes(input logic [FormW-1:0] f,
                                              input logic [ByteW-1:0] modrm);
        logic [1:0] n;
        if (f == FORM_MEM_ACC || f == FORM_ACC_MEM) n = 2'd2;
        else if (f == FORM_IMM_REG)                 n = 2'd0;
        else if (modrm[7:6] == MOD_DISP8)           n = 2'd1;
        else if (modrm[7:6] == MOD_DISP16)          n = 2'd2;
        else if (modrm[7:6] == MOD_MEM && modrm[2:0] == RM_DIRECT) n = 2'd2;
        else                                        n = 2'd0;
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/xmd_stream_if.sv =====
`default_nettype none

interface xmd_byte_if;
    logic                       valid;
    logic                       ready;
    logic [xmd_pkg::ByteW-1:0]  code_byte;

    modport source (output valid, output code_byte, input ready);
    modport sink   (input valid, input code_byte, output ready);
endinterface

interface xmd_rec_if;
    logic             valid;
    logic             ready;
    xmd_pkg::t_result result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

`default_nettype wire

// ===== rtl/x86_mov_instruction_decoder_top.sv =====
`default_nettype none

// Port     Dir  Payload                         Request
// i_code   in   code_byte (8 bits)              one byte of the code stream
// o_rec    out  t_result record (decoded MOV)   one record per instruction or bad byte
//
// One byte per cycle is taken while no record is stalled; a byte passes the
// input register and then the decode step, which registers its record.
// The decode state and the result register share one step of logic.
// Synchronous active-low reset returns the decoder to opcode phase, offset 0.
// A stalled record holds o_rec and stops the decode step; the input register
// then fills and i_code.ready drops.

module x86_mov_instruction_decoder_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    xmd_byte_if.sink        i_code,
    xmd_rec_if.source       o_rec
);

    typedef enum logic [2:0] {
        PH_OPCODE  = 3'd0,
        PH_MODRM   = 3'd1,
        PH_DISP_LO = 3'd2,
        PH_DISP_HI = 3'd3,
        PH_IMM_LO  = 3'd4,
        PH_IMM_HI  = 3'd5
    } t_phase;

    logic                          r_byte_valid;
    logic [xmd_pkg::ByteW-1:0]     r_byte;

    t_phase                        r_phase, n_phase;
    logic [xmd_pkg::ByteW-1:0]     r_opcode, n_opcode;
    logic [xmd_pkg::ByteW-1:0]     r_modrm, n_modrm;
    logic [xmd_pkg::WordW-1:0]     r_disp, n_disp;
    logic [xmd_pkg::WordW-1:0]     r_imm, n_imm;
    logic [xmd_pkg::LenW-1:0]      r_taken, n_taken;
    logic [xmd_pkg::WordW-1:0]     r_offset;
    logic [xmd_pkg::WordW-1:0]     r_start, n_start;

    logic                          r_out_valid;
    xmd_pkg::t_result              r_out, n_out;

    logic                          out_free;
    logic                          advance;
    logic                          emit;
    logic                          unknown;
    logic [xmd_pkg::FormW-1:0]     cur_form;

    assign out_free     = !r_out_valid || o_rec.ready;
    assign advance      = r_byte_valid && out_free;
    assign i_code.ready = !r_byte_valid || out_free;
    assign o_rec.valid  = r_out_valid;
    assign o_rec.result = r_out;
    assign cur_form     = xmd_pkg::op_form(r_opcode);

    always_comb begin
        n_phase  = r_phase;
        n_opcode = r_opcode;
        n_modrm  = r_modrm;
        n_disp   = r_disp;
        n_imm    = r_imm;
        n_taken  = r_taken;
        n_start  = r_start;
        emit     = 1'b0;
        unknown  = 1'b0;
        unique case (r_phase)
            PH_MODRM: begin
                n_modrm = r_byte;
                n_taken = r_taken + 3'd1;
                if (xmd_pkg::disp_bytes(cur_form, r_byte) != 2'd0) begin
                    n_phase = PH_DISP_LO;
                end else if (cur_form == xmd_pkg::FORM_IMM_RM) begin
                    n_phase = PH_IMM_LO;
                end else begin
                    emit = 1'b1;
                end
            end
            PH_DISP_LO: begin
                n_taken = r_taken + 3'd1;
                if (xmd_pkg::disp_bytes(cur_form, r_modrm) == 2'd1) begin
                    n_disp = {{8{r_byte[7]}}, r_byte};
                    if (cur_form == xmd_pkg::FORM_IMM_RM) begin
                        n_phase = PH_IMM_LO;
                    end else begin
                        emit = 1'b1;
                    end
                end else begin
                    n_disp  = {8'h00, r_byte};
                    n_phase = PH_DISP_HI;
                end
            end
            PH_DISP_HI: begin
                n_disp  = {r_byte, r_disp[7:0]};
                n_taken = r_taken + 3'd1;
                if (cur_form == xmd_pkg::FORM_IMM_RM) begin
                    n_phase = PH_IMM_LO;
                end else begin
                    emit = 1'b1;
                end
            end
            PH_IMM_LO: begin
                n_imm   = {8'h00, r_byte};
                n_taken = r_taken + 3'd1;
                if (xmd_pkg::op_wide(r_opcode)) begin
                    n_phase = PH_IMM_HI;
                end else begin
                    emit = 1'b1;
                end
            end
            PH_IMM_HI: begin
                n_imm   = {r_byte, r_imm[7:0]};
                n_taken = r_taken + 3'd1;
                emit    = 1'b1;
            end
            default: begin
                n_phase = PH_OPCODE;
                if (!xmd_pkg::op_known(r_byte)) begin
                    unknown = 1'b1;
                end else begin
                    n_opcode = r_byte;
                    n_modrm  = '0;
                    n_disp   = '0;
                    n_imm    = '0;
                    n_taken  = 3'd1;
                    n_start  = r_offset;
                    unique case (xmd_pkg::op_form(r_byte))
                        xmd_pkg::FORM_IMM_REG:                       n_phase = PH_IMM_LO;
                        xmd_pkg::FORM_RM_REG, xmd_pkg::FORM_IMM_RM:  n_phase = PH_MODRM;
                        default:                                     n_phase = PH_DISP_LO;
                    endcase
                end
            end
        endcase
        if (emit) begin
            n_phase = PH_OPCODE;
        end
    end

    // Result record, built from the held fields as they stand after this byte.
    always_comb begin
        logic has_modrm;
        has_modrm = (cur_form == xmd_pkg::FORM_RM_REG) || (cur_form == xmd_pkg::FORM_IMM_RM);
        n_out = '0;
        if (unknown) begin
            n_out.status       = xmd_pkg::STATUS_UNKNOWN;
            n_out.length       = 3'd1;
            n_out.start_offset = r_offset;
        end else begin
            n_out.form           = cur_form;
            n_out.status         = xmd_pkg::STATUS_OK;
            n_out.word_flag      = xmd_pkg::op_wide(r_opcode);
            n_out.direction_flag = (cur_form == xmd_pkg::FORM_RM_REG) ? r_opcode[1] : 1'b0;
            n_out.mode           = has_modrm ? n_modrm[7:6] : 2'd0;
            if (cur_form == xmd_pkg::FORM_IMM_REG) begin
                n_out.reg_field = r_opcode[2:0];
            end else if (has_modrm) begin
                n_out.reg_field = n_modrm[5:3];
            end
            n_out.rm_field     = has_modrm ? n_modrm[2:0] : 3'd0;
            n_out.displacement = n_disp;
            n_out.immediate    = n_imm;
            n_out.length       = n_taken;
            n_out.start_offset = r_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_valid <= 1'b0;
            r_phase      <= PH_OPCODE;
            r_offset     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_code.ready) begin
                r_byte_valid <= i_code.valid;
            end
            if (advance) begin
                r_phase  <= n_phase;
                r_offset <= r_offset + 16'd1;
            end
            if (advance && (emit || unknown)) begin
                r_out_valid <= 1'b1;
            end else if (o_rec.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_code.valid && i_code.ready) begin
            r_byte <= i_code.code_byte;
        end
        if (advance) begin
            r_opcode <= n_opcode;
            r_modrm  <= n_modrm;
            r_disp   <= n_disp;
            r_imm    <= n_imm;
            r_taken  <= n_taken;
            r_start  <= n_start;
        end
        if (advance && (emit || unknown)) begin
            r_out <= n_out;
        end
    end

    a_unknown_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == xmd_pkg::STATUS_UNKNOWN)
            |-> (r_out.length == 3'd1 && r_out.form == xmd_pkg::FORM_IMM_REG))
        else $error("unknown-opcode record carries decoded fields");

    a_length_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.length != 3'd0 && r_out.length <= 3'd6))
        else $error("record length out of range");

    a_back_to_opcode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && emit) |=> (r_phase == PH_OPCODE))
        else $error("decoder did not return to opcode phase after a record");

    a_offset_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_offset == $past(r_offset) + 16'd1))
        else $error("stream offset did not advance by one byte");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rec.ready) |-> !advance)
        else $error("decode step ran while a record was stalled");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none

module tb_top;

    localparam int DirRows     = 27;
    localparam int RandomItems = 680;
    localparam int BurstItems  = 200;
    localparam int HoldCycles  = 80;
    localparam int DrainCycles = 10;
    localparam int CycleLimit  = 30000;

    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_MODRM,
        PH_DISP_LO,
        PH_DISP_HI,
        PH_IMM_LO,
        PH_IMM_HI
    } t_dec_phase;

    typedef struct packed {
        logic [xmd_pkg::ByteW-1:0] code;
        logic                      typed;
        xmd_pkg::t_result          want;
    } t_dir_row;

    localparam xmd_pkg::t_result NO_REC = '0;

    // Directed stream; offsets start at 0 after reset.
    localparam t_dir_row DIR_ROWS [DirRows] = '{
        // Two bytes that are no opcode at all, right after reset.
        '{8'h00, 1'b1, '{xmd_pkg::FORM_IMM_REG, xmd_pkg::STATUS_UNKNOWN,
                         1'b0, 1'b0, 2'd0, 3'd0, 3'd0,
                         16'h0000, 16'h0000, 3'd1, 16'd0}},
        '{8'hff, 1'b1, '{xmd_pkg::FORM_IMM_REG, xmd_pkg::STATUS_UNKNOWN,
                         1'b0, 1'b0, 2'd0, 3'd0, 3'd0,
                         16'h0000, 16'h0000, 3'd1, 16'd1}},
        // mov di, 0xffff
        '{8'hbf, 1'b0, NO_REC},
        '{8'hff, 1'b0, NO_REC},
        '{8'hff, 1'b1, '{xmd_pkg::FORM_IMM_REG, xmd_pkg::STATUS_OK,
                         1'b1, 1'b0, 2'd0, 3'd7, 3'd0,
                         16'h0000, 16'hffff, 3'd3, 16'd2}},
        // Longest form: word immediate to a direct address.
        '{8'hc7, 1'b0, NO_REC},
        '{8'h06, 1'b0, NO_REC},
        '{8'hff, 1'b0, NO_REC},
        '{8'hff, 1'b0, NO_REC},
        '{8'hff, 1'b0, NO_REC},
        '{8'hff, 1'b0, NO_REC},
        // Negative 8-bit displacement, sign-extended.
        '{8'h88, 1'b0, NO_REC},
        '{8'h40, 1'b0, NO_REC},
        '{8'h80, 1'b0, NO_REC},
        // Immediate to memory with an 8-bit displacement.
        '{8'hc6, 1'b0, NO_REC},
        '{8'h45, 1'b0, NO_REC},
        '{8'h80, 1'b0, NO_REC},
        '{8'h7f, 1'b0, NO_REC},
        // Immediate to register through the r/m form, nonzero reg bits.
        '{8'hc6, 1'b0, NO_REC},
        '{8'hf8, 1'b0, NO_REC},
        '{8'h55, 1'b0, NO_REC},
        '{8'ha1, 1'b0, NO_REC},
        '{8'h00, 1'b0, NO_REC},
        '{8'h00, 1'b0, NO_REC},
        '{8'ha2, 1'b0, NO_REC},
        '{8'hff, 1'b0, NO_REC},
        '{8'hff, 1'b0, NO_REC}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    xmd_byte_if code_if ();
    xmd_rec_if  rec_if ();

    x86_mov_instruction_decoder_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_code  (code_if),
        .o_rec   (rec_if)
    );

    // Decoder state as predicted from the accepted byte stream.
    t_dec_phase                ph;
    logic [xmd_pkg::ByteW-1:0] held_op;
    logic [xmd_pkg::FormW-1:0] held_form;
    logic                      held_wide;
    logic [xmd_pkg::ByteW-1:0] held_modrm;
    logic [xmd_pkg::WordW-1:0] held_disp;
    logic [xmd_pkg::WordW-1:0] held_imm;
    logic [xmd_pkg::LenW-1:0]  taken;
    logic [xmd_pkg::WordW-1:0] pos;
    logic [xmd_pkg::WordW-1:0] held_start;

    xmd_pkg::t_result pending_records [$];
    int               mismatches = 0;
    int               bytes_fed;
    int               cycle_count;
    bit               hold_req;
    bit               no_idle;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic int addr_len(input logic [xmd_pkg::FormW-1:0] f,
                                    input logic [xmd_pkg::ByteW-1:0] modrm);
        if (f == xmd_pkg::FORM_MEM_ACC || f == xmd_pkg::FORM_ACC_MEM) return 2;
        if (f == xmd_pkg::FORM_IMM_REG) return 0;
        if (modrm[7:6] == xmd_pkg::MOD_DISP8) return 1;
        if (modrm[7:6] == xmd_pkg::MOD_DISP16) return 2;
        if (modrm[7:6] == xmd_pkg::MOD_MEM && modrm[2:0] == xmd_pkg::RM_DIRECT) return 2;
        return 0;
    endfunction

    function automatic xmd_pkg::t_result make_record();
        xmd_pkg::t_result r;
        bit               has_modrm;
        has_modrm = (held_form == xmd_pkg::FORM_RM_REG) || (held_form == xmd_pkg::FORM_IMM_RM);
        r = '0;
        r.form           = held_form;
        r.status         = xmd_pkg::STATUS_OK;
        r.word_flag      = held_wide;
        r.direction_flag = (held_form == xmd_pkg::FORM_RM_REG) ? held_op[1] : 1'b0;
        if (has_modrm) begin
            r.mode      = held_modrm[7:6];
            r.reg_field = held_modrm[5:3];
            r.rm_field  = held_modrm[2:0];
        end else if (held_form == xmd_pkg::FORM_IMM_REG) begin
            r.reg_field = held_op[2:0];
        end
        r.displacement = held_disp;
        r.immediate    = held_imm;
        r.length       = taken;
        r.start_offset = held_start;
        return r;
    endfunction

    task automatic decode_byte(input logic [xmd_pkg::ByteW-1:0] b, output bit got,
                               output xmd_pkg::t_result rec);
        logic [xmd_pkg::WordW-1:0] here;
        logic [xmd_pkg::FormW-1:0] f;
        bit                        known;
        bit                        addr_done;
        bit                        all_done;
        here      = pos;
        pos       = pos + 16'd1;
        got       = 1'b0;
        rec       = '0;
        addr_done = 1'b0;
        all_done  = 1'b0;
        case (ph)
            PH_MODRM: begin
                held_modrm = b;
                taken++;
                if (addr_len(held_form, held_modrm) != 0) ph = PH_DISP_LO;
                else addr_done = 1'b1;
            end
            PH_DISP_LO: begin
                taken++;
                if (addr_len(held_form, held_modrm) == 1) begin
                    held_disp = {{8{b[7]}}, b};
                    addr_done = 1'b1;
                end else begin
                    held_disp = {8'h00, b};
                    ph = PH_DISP_HI;
                end
            end
            PH_DISP_HI: begin
                held_disp[15:8] = b;
                taken++;
                addr_done = 1'b1;
            end
            PH_IMM_LO: begin
                held_imm = {8'h00, b};
                taken++;
                if (held_wide) ph = PH_IMM_HI;
                else all_done = 1'b1;
            end
            PH_IMM_HI: begin
                held_imm[15:8] = b;
                taken++;
                all_done = 1'b1;
            end
            default: begin
                known = 1'b1;
                f     = xmd_pkg::FORM_IMM_REG;
                if ((b & xmd_pkg::MASK_IMM_REG) == xmd_pkg::PAT_IMM_REG)
                    f = xmd_pkg::FORM_IMM_REG;
                else if ((b & xmd_pkg::MASK_RM_REG) == xmd_pkg::PAT_RM_REG)
                    f = xmd_pkg::FORM_RM_REG;
                else if ((b & xmd_pkg::MASK_PAIR) == xmd_pkg::PAT_IMM_RM)
                    f = xmd_pkg::FORM_IMM_RM;
                else if ((b & xmd_pkg::MASK_PAIR) == xmd_pkg::PAT_MEM_ACC)
                    f = xmd_pkg::FORM_MEM_ACC;
                else if ((b & xmd_pkg::MASK_PAIR) == xmd_pkg::PAT_ACC_MEM)
                    f = xmd_pkg::FORM_ACC_MEM;
                else
                    known = 1'b0;
                ph = PH_OPCODE;
                if (!known) begin
                    got              = 1'b1;
                    rec.status       = xmd_pkg::STATUS_UNKNOWN;
                    rec.length       = 3'd1;
                    rec.start_offset = here;
                end else begin
                    held_op    = b;
                    held_form  = f;
                    held_wide  = (f == xmd_pkg::FORM_IMM_REG) ? b[3] : b[0];
                    held_modrm = '0;
                    held_disp  = '0;
                    held_imm   = '0;
                    taken      = 3'd1;
                    held_start = here;
                    if (f == xmd_pkg::FORM_IMM_REG) ph = PH_IMM_LO;
                    else if (f == xmd_pkg::FORM_RM_REG || f == xmd_pkg::FORM_IMM_RM)
                        ph = PH_MODRM;
                    else ph = PH_DISP_LO;
                end
            end
        endcase
        if (addr_done) begin
            if (held_form == xmd_pkg::FORM_IMM_RM) ph = PH_IMM_LO;
            else all_done = 1'b1;
        end
        if (all_done) begin
            got = 1'b1;
            rec = make_record();
            ph  = PH_OPCODE;
        end
    endtask

    // The valid stays high from one request to the next unless the sender idles.
    task automatic offer_byte(input logic [xmd_pkg::ByteW-1:0] b, input bit may_idle,
                              input bit typed, input xmd_pkg::t_result typed_rec);
        bit               got;
        xmd_pkg::t_result rec;
        while (may_idle && $urandom_range(99) < 34) begin
            code_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        code_if.valid     <= 1'b1;
        code_if.code_byte <= b;
        do @(posedge i_clk); while (!code_if.ready);
        decode_byte(b, got, rec);
        if (got) pending_records.push_back(typed ? typed_rec : rec);
        bytes_fed++;
    endtask

    task automatic send_random_instr(input bit may_idle);
        logic [xmd_pkg::ByteW-1:0] bytes_q [$];
        logic [xmd_pkg::ByteW-1:0] op;
        logic [xmd_pkg::ByteW-1:0] modrm;
        logic [xmd_pkg::FormW-1:0] f;
        if ($urandom_range(99) < 12) begin
            bytes_q.push_back(8'($urandom_range(255)));
        end else begin
            f = 3'($urandom_range(4));
            case (f)
                xmd_pkg::FORM_IMM_REG: op = xmd_pkg::PAT_IMM_REG | 8'($urandom_range(15));
                xmd_pkg::FORM_RM_REG:  op = xmd_pkg::PAT_RM_REG | 8'($urandom_range(3));
                xmd_pkg::FORM_IMM_RM:  op = xmd_pkg::PAT_IMM_RM | 8'($urandom_range(1));
                xmd_pkg::FORM_MEM_ACC: op = xmd_pkg::PAT_MEM_ACC | 8'($urandom_range(1));
                default:               op = xmd_pkg::PAT_ACC_MEM | 8'($urandom_range(1));
            endcase
            modrm = 8'($urandom_range(255));
            bytes_q.push_back(op);
            if (f == xmd_pkg::FORM_RM_REG || f == xmd_pkg::FORM_IMM_RM) bytes_q.push_back(modrm);
            repeat (addr_len(f, modrm)) bytes_q.push_back(8'($urandom_range(255)));
            if (f == xmd_pkg::FORM_IMM_REG) begin
                repeat (op[3] ? 2 : 1) bytes_q.push_back(8'($urandom_range(255)));
            end else if (f == xmd_pkg::FORM_IMM_RM) begin
                repeat (op[0] ? 2 : 1) bytes_q.push_back(8'($urandom_range(255)));
            end
            // Now and then cut an instruction short so the next opcode lands as data.
            if ($urandom_range(19) == 0) void'(bytes_q.pop_back());
        end
        foreach (bytes_q[i]) offer_byte(bytes_q[i], may_idle, 1'b0, NO_REC);
    endtask

    task automatic note_mismatch(input string field, input logic [15:0] want,
                                 input logic [15:0] seen);
        mismatches++;
        $error("%s: expected 0x%0h, got 0x%0h", field, want, seen);
    endtask

    always @(posedge i_clk) begin : check_record
        xmd_pkg::t_result want;
        xmd_pkg::t_result seen;
        if (i_rst_n && rec_if.valid && rec_if.ready) begin
            seen = rec_if.result;
            if (pending_records.size() == 0) begin
                mismatches++;
                $error("record with none pending: start_offset 0x%0h", seen.start_offset);
            end else begin
                want = pending_records.pop_front();
                if (seen.form !== want.form)
                    note_mismatch("form", 16'(want.form), 16'(seen.form));
                if (seen.status !== want.status)
                    note_mismatch("status", 16'(want.status), 16'(seen.status));
                if (seen.word_flag !== want.word_flag)
                    note_mismatch("word_flag", 16'(want.word_flag), 16'(seen.word_flag));
                if (seen.direction_flag !== want.direction_flag)
                    note_mismatch("direction_flag", 16'(want.direction_flag),
                                  16'(seen.direction_flag));
                if (seen.mode !== want.mode)
                    note_mismatch("mode", 16'(want.mode), 16'(seen.mode));
                if (seen.reg_field !== want.reg_field)
                    note_mismatch("reg_field", 16'(want.reg_field), 16'(seen.reg_field));
                if (seen.rm_field !== want.rm_field)
                    note_mismatch("rm_field", 16'(want.rm_field), 16'(seen.rm_field));
                if (seen.displacement !== want.displacement)
                    note_mismatch("displacement", want.displacement, seen.displacement);
                if (seen.immediate !== want.immediate)
                    note_mismatch("immediate", want.immediate, seen.immediate);
                if (seen.length !== want.length)
                    note_mismatch("length", 16'(want.length), 16'(seen.length));
                if (seen.start_offset !== want.start_offset)
                    note_mismatch("start_offset", want.start_offset, seen.start_offset);
            end
        end
    end

    initial begin
        int hold_left;
        bit hold_taken;
        hold_left    = 0;
        hold_taken   = 1'b0;
        rec_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HoldCycles;
            end
            if (hold_left > 0) begin
                rec_if.ready <= 1'b0;
                hold_left--;
            end else begin
                rec_if.ready <= no_idle || ($urandom_range(99) >= 34);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CycleLimit) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** x86_mov_instruction_decoder_top: FAILED **");
        $finish;
    end

    initial begin
        hold_req          = 1'b0;
        no_idle           = 1'b0;
        bytes_fed         = 0;
        code_if.valid     = 1'b0;
        code_if.code_byte = '0;
        ph         = PH_OPCODE;
        held_op    = '0;
        held_form  = xmd_pkg::FORM_IMM_REG;
        held_wide  = 1'b0;
        held_modrm = '0;
        held_disp  = '0;
        held_imm   = '0;
        taken      = '0;
        pos        = '0;
        held_start = '0;

        wait (i_rst_n === 1'b1);
        @(posedge i_clk);

        for (int i = 0; i < DirRows; i++)
            offer_byte(DIR_ROWS[i].code, 1'b1, DIR_ROWS[i].typed, DIR_ROWS[i].want);

        while (bytes_fed < DirRows + RandomItems) begin
            // A long hold-off on the record side while bytes keep coming.
            if (bytes_fed >= DirRows + RandomItems / 3) hold_req = 1'b1;
            send_random_instr(1'b1);
        end

        // Let every record come out before the stretch without gaps.
        code_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_records.size() != 0);

        // A stretch of back-to-back bytes with the record side always ready.
        no_idle = 1'b1;
        while (bytes_fed < DirRows + RandomItems + BurstItems) send_random_instr(1'b0);
        no_idle = 1'b0;

        code_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_records.size() != 0);
        repeat (DrainCycles) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("** x86_mov_instruction_decoder_top: PASSED **");
        end else begin
            $display("** x86_mov_instruction_decoder_top: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
